// ----- rtl/rtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rtt_pkg: resource text tokenizer package
// Shared widths, character codes, lexer modes and queue entry types.
// ----------------------------------------------------------------------------
package rtt_pkg;

  // Line counter width and the width of the reported line number
  localparam int LINE_BITS   = 24;
  localparam int LINE_NUM_W  = 24;
  localparam int LINE_WIDE_W = (LINE_BITS > LINE_NUM_W) ? LINE_BITS : LINE_NUM_W;

  // Result queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_SLASH     = 3'd1,
    MODE_COMMENT   = 3'd2,
    MODE_WORD      = 3'd3,
    MODE_WORD_ESC  = 3'd4,
    MODE_QUOTE     = 3'd5,
    MODE_QUOTE_ESC = 3'd6
  } rtt_mode_e;

  // One result beat, less line number and last flag
  typedef struct packed {
    logic       has_byte;
    logic [7:0] tok_byte;
    logic       ends_token;
    logic       unterm;
  } rtt_result_t;

  // Queue entry: the one or two results caused by one input beat
  typedef struct packed {
    rtt_result_t            res0;
    rtt_result_t            res1;
    logic                   two;
    logic [LINE_NUM_W-1:0]  line_number;
  } rtt_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } rtt_q_status_t;

  // Map the character after a backslash
  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] m;
    m = c;
    if (c == CH_LC_N) m = CH_LF;
    else if (c == CH_LC_R) m = CH_CR;
    else if (c == CH_LC_T) m = CH_TAB;
    return m;
  endfunction

  // Bytes that close a bare word
  function automatic logic ends_word(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR) ||
           (c == CH_EQ) || (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  // Low bits of the line counter as reported
  function automatic logic [LINE_NUM_W-1:0] line_report(input logic [LINE_BITS-1:0] cnt);
    logic [LINE_WIDE_W-1:0] w;
    w = LINE_WIDE_W'(cnt);
    return w[LINE_NUM_W-1:0];
  endfunction

endpackage

// ----- rtl/rtt_if.sv -----
// ----------------------------------------------------------------------------
// rtt_in_if / rtt_out_if: tokenizer stream channels
// Valid/ready channels for text bytes in and token results out.
// ----------------------------------------------------------------------------
interface rtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface rtt_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  token_byte;
  logic        ends_token;
  logic        unterminated_quote;
  logic [23:0] line_number;
  logic        last_result;

  modport source (output valid, has_byte, token_byte, ends_token, unterminated_quote,
                  line_number, last_result, input ready);
  modport sink   (input valid, has_byte, token_byte, ends_token, unterminated_quote,
                  line_number, last_result, output ready);
endinterface

// ----- rtl/resource_text_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// resource_text_tokenizer_top: resource text tokenizer
// Splits a byte stream into tokens with line numbers and token-end marks.
// ----------------------------------------------------------------------------
// The tokenizer takes one text byte per cycle on in_i and emits token results
// on out_o. Each byte gives zero, one or two results; the lexer front end
// handles each byte as it is accepted and pushes its results into a four-entry
// queue, and the emitter drains the queue at one result beat per cycle while
// out_o is ready. The input stalls only when the queue is full. Bytes that give no
// result (whitespace, comments, quote or backslash openers) leave the output
// untouched. A beat with end_of_text closes any open token and restarts the
// lexer and the line count at line one.
module resource_text_tokenizer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  rtt_in_if.sink         in_i,
  rtt_out_if.source      out_o
);
  import rtt_pkg::*;

  logic            push, pop;
  rtt_entry_t      push_data, pop_data;
  rtt_q_status_t   q_status;

  // Lexer: classify bytes and queue their results
  rtt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .ready_o       (in_i.ready),
    .text_byte_i   (in_i.text_byte),
    .end_of_text_i (in_i.end_of_text),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // Result queue
  rtt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Emitter: send queued results as output beats
  rtt_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_status_i           (q_status),
    .pop_data_i           (pop_data),
    .pop_o                (pop),
    .valid_o              (out_o.valid),
    .ready_i              (out_o.ready),
    .has_byte_o           (out_o.has_byte),
    .token_byte_o         (out_o.token_byte),
    .ends_token_o         (out_o.ends_token),
    .unterminated_quote_o (out_o.unterminated_quote),
    .line_number_o        (out_o.line_number),
    .last_result_o        (out_o.last_result)
  );

endmodule

// ----- rtl/rtt_front.sv -----
// ----------------------------------------------------------------------------
// rtt_front: tokenizer lexer front end
// Accepts one text byte per cycle while the queue is not full, updates lexer
// mode and line count, and pushes the byte's results into the result queue.
// ----------------------------------------------------------------------------
module rtt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [7:0]                  text_byte_i,
  input  logic                        end_of_text_i,
  input  rtt_pkg::rtt_q_status_t      q_status_i,
  output logic                        push_o,
  output rtt_pkg::rtt_entry_t         push_data_o
);
  import rtt_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  rtt_mode_e              mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic                   accept;

  // Between-token handling of the current byte
  logic        idle_emit, idle_ends, idle_bump;
  rtt_mode_e   idle_mode;

  // Results of this beat
  logic        v0, v1, bump;
  rtt_result_t r0, r1;
  logic [7:0]  c;

  assign c       = text_byte_i;
  assign ready_o = !q_status_i.full;
  assign accept  = valid_i && ready_o;

  // Classify a byte seen between tokens
  always_comb begin
    idle_emit = 1'b0;
    idle_ends = 1'b0;
    idle_bump = 1'b0;
    idle_mode = MODE_IDLE;
    if ((c == CH_SP) || (c == CH_TAB) || (c == CH_CR)) begin
      idle_mode = MODE_IDLE;
    end else if (c == CH_LF) begin
      idle_bump = 1'b1;
    end else if (c == CH_SLASH) begin
      idle_mode = MODE_SLASH;
    end else if (c == CH_QUOTE) begin
      idle_mode = MODE_QUOTE;
    end else if ((c == CH_EQ) || (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_HASH)) begin
      idle_emit = 1'b1;
      idle_ends = 1'b1;
    end else if (c == CH_BSLASH) begin
      idle_mode = MODE_WORD_ESC;
    end else begin
      idle_emit = 1'b1;
      idle_mode = MODE_WORD;
    end
  end

  // Lexer step: results, next mode and line bump
  always_comb begin
    v0     = 1'b0;
    v1     = 1'b0;
    r0     = '0;
    r1     = '0;
    bump   = 1'b0;
    mode_d = mode_q;
    if (end_of_text_i) begin
      // Close whatever is open, then return to reset state
      mode_d = MODE_IDLE;
      unique case (mode_q)
        MODE_SLASH: begin
          v0 = 1'b1;
          r0 = '{has_byte: 1'b1, tok_byte: CH_SLASH, ends_token: 1'b1, unterm: 1'b0};
        end
        MODE_WORD, MODE_WORD_ESC: begin
          v0 = 1'b1;
          r0 = '{has_byte: 1'b0, tok_byte: 8'h00, ends_token: 1'b1, unterm: 1'b0};
        end
        MODE_QUOTE, MODE_QUOTE_ESC: begin
          v0 = 1'b1;
          r0 = '{has_byte: 1'b0, tok_byte: 8'h00, ends_token: 1'b1, unterm: 1'b1};
        end
        default: begin
          v0 = 1'b0;
        end
      endcase
    end else begin
      unique case (mode_q)
        MODE_SLASH: begin
          v0 = (c != CH_SLASH);
          r0 = '{has_byte: 1'b1, tok_byte: CH_SLASH, ends_token: 1'b0, unterm: 1'b0};
          if (c == CH_SLASH) begin
            mode_d = MODE_COMMENT;
          end else if (ends_word(c)) begin
            r0.ends_token = 1'b1;
            v1     = idle_emit;
            r1     = '{has_byte: 1'b1, tok_byte: c, ends_token: idle_ends, unterm: 1'b0};
            bump   = idle_bump;
            mode_d = idle_mode;
          end else if (c == CH_BSLASH) begin
            mode_d = MODE_WORD_ESC;
          end else begin
            v1     = 1'b1;
            r1     = '{has_byte: 1'b1, tok_byte: c, ends_token: 1'b0, unterm: 1'b0};
            mode_d = MODE_WORD;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            bump   = 1'b1;
            mode_d = MODE_IDLE;
          end else if (c == CH_CR) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_WORD: begin
          if (ends_word(c)) begin
            v0     = 1'b1;
            r0     = '{has_byte: 1'b0, tok_byte: 8'h00, ends_token: 1'b1, unterm: 1'b0};
            v1     = idle_emit;
            r1     = '{has_byte: 1'b1, tok_byte: c, ends_token: idle_ends, unterm: 1'b0};
            bump   = idle_bump;
            mode_d = idle_mode;
          end else if (c == CH_BSLASH) begin
            mode_d = MODE_WORD_ESC;
          end else begin
            v0 = 1'b1;
            r0 = '{has_byte: 1'b1, tok_byte: c, ends_token: 1'b0, unterm: 1'b0};
          end
        end
        MODE_WORD_ESC: begin
          v0     = 1'b1;
          r0     = '{has_byte: 1'b1, tok_byte: map_escape(c), ends_token: 1'b0, unterm: 1'b0};
          mode_d = MODE_WORD;
        end
        MODE_QUOTE: begin
          if (c == CH_QUOTE) begin
            v0     = 1'b1;
            r0     = '{has_byte: 1'b0, tok_byte: 8'h00, ends_token: 1'b1, unterm: 1'b0};
            mode_d = MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_d = MODE_QUOTE_ESC;
          end else begin
            bump = (c == CH_LF);
            v0   = 1'b1;
            r0   = '{has_byte: 1'b1, tok_byte: c, ends_token: 1'b0, unterm: 1'b0};
          end
        end
        MODE_QUOTE_ESC: begin
          v0     = 1'b1;
          r0     = '{has_byte: 1'b1, tok_byte: map_escape(c), ends_token: 1'b0, unterm: 1'b0};
          mode_d = MODE_QUOTE;
        end
        default: begin
          v0     = idle_emit;
          r0     = '{has_byte: 1'b1, tok_byte: c, ends_token: idle_ends, unterm: 1'b0};
          bump   = idle_bump;
          mode_d = idle_mode;
        end
      endcase
    end
  end

  // Saturating line count; end of text restarts at line one
  always_comb begin
    line_d = line_q;
    if (bump && (line_q != LINE_MAX)) begin
      line_d = line_q + LINE_ONE;
    end
  end

  // Push the beat's results; line number is after this byte, before restart
  assign push_o                  = accept && v0;
  assign push_data_o.res0        = r0;
  assign push_data_o.res1        = r1;
  assign push_data_o.two         = v1;
  assign push_data_o.line_number = line_report(line_d);

  // Hold lexer state between accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= LINE_ONE;
    end else if (accept) begin
      if (end_of_text_i) begin
        mode_q <= MODE_IDLE;
        line_q <= LINE_ONE;
      end else begin
        mode_q <= mode_d;
        line_q <= line_d;
      end
    end
  end

endmodule

// ----- rtl/rtt_fifo.sv -----
// ----------------------------------------------------------------------------
// rtt_fifo: result queue
// Short register queue that decouples the lexer from the result emitter.
// ----------------------------------------------------------------------------
module rtt_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  rtt_pkg::rtt_entry_t       push_data_i,
  input  logic                      pop_i,
  output rtt_pkg::rtt_entry_t       pop_data_o,
  output rtt_pkg::rtt_q_status_t    status_o
);
  import rtt_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_ONE = QPTR_W'(1);
  localparam logic [QCNT_W-1:0] CNT_ONE = QCNT_W'(1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

  rtt_entry_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_FULL);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PTR_ONE;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PTR_ONE;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_ONE;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_ONE;
      end
    end
  end

endmodule

// ----- rtl/rtt_back.sv -----
// ----------------------------------------------------------------------------
// rtt_back: tokenizer result emitter
// Pops queue entries and sends their one or two results as output beats.
// ----------------------------------------------------------------------------
module rtt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rtt_pkg::rtt_q_status_t    q_status_i,
  input  rtt_pkg::rtt_entry_t       pop_data_i,
  output logic                      pop_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic                      has_byte_o,
  output logic [7:0]                token_byte_o,
  output logic                      ends_token_o,
  output logic                      unterminated_quote_o,
  output logic [23:0]               line_number_o,
  output logic                      last_result_o
);
  import rtt_pkg::*;

  rtt_entry_t   cur_q;
  logic         busy_q;
  logic         idx_q;
  rtt_result_t  sel;
  logic         last, out_take, load;

  // Pick the result slot being sent
  assign sel      = idx_q ? cur_q.res1 : cur_q.res0;
  assign last     = !cur_q.two || idx_q;
  assign out_take = busy_q && ready_i;
  assign load     = (!busy_q || (out_take && last)) && !q_status_i.empty;
  assign pop_o    = load;

  assign valid_o              = busy_q;
  assign has_byte_o           = sel.has_byte;
  assign token_byte_o         = sel.tok_byte;
  assign ends_token_o         = sel.ends_token;
  assign unterminated_quote_o = sel.unterm;
  assign line_number_o        = cur_q.line_number;
  assign last_result_o        = last;

  // Hold the current entry's payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= pop_data_i;
    end
  end

  // Step through the entry's results, then take the next entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 1'b0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= 1'b0;
    end else if (out_take) begin
      if (last) begin
        busy_q <= 1'b0;
        idx_q  <= 1'b0;
      end else begin
        idx_q  <= 1'b1;
      end
    end
  end

endmodule
